// ----- design/jsu_pkg.sv -----
// jsu_pkg: shared types, byte codes and helper functions for the JSON string
// unescape block. No dependencies.
`default_nettype none

package jsu_pkg;

    typedef enum logic [2:0] {
        K_DATA    = 3'd0,
        K_DONE    = 3'd1,
        K_NOQUOTE = 3'd2,
        K_TRAILBS = 3'd3,
        K_SHORTU  = 3'd4,
        K_BADHEX  = 3'd5,
        K_UNKESC  = 3'd6,
        K_UNTERM  = 3'd7
    } t_kind;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_STR  = 2'd1,
        PH_ESC  = 2'd2,
        PH_HEX  = 2'd3
    } t_phase;

    // results produced by one input word, sent in order from slot 0
    typedef struct packed {
        logic [1:0]      cnt;
        t_kind           kind;
        logic [2:0][7:0] bytes;
    } t_group;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_B      = 8'h62;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // bit 4 set when c is a hex digit, low nibble is its value
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic t_group utf8_enc(input logic [15:0] cp);
        t_group g;
        g.kind  = K_DATA;
        g.bytes = '0;
        if (cp[15:7] == 9'd0) begin
            g.cnt      = 2'd1;
            g.bytes[0] = cp[7:0];
        end else if (cp[15:11] == 5'd0) begin
            g.cnt      = 2'd2;
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
        end else begin
            g.cnt      = 2'd3;
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
        end
        return g;
    endfunction

endpackage

`default_nettype wire

// ----- design/jsu_decode.sv -----
// jsu_decode: string state machine; decodes one input word into a group of
// up to three results. Depends on jsu_pkg.
`default_nettype none

module jsu_decode (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_fire,
    input  wire [7:0]       i_byte,
    input  wire             i_end,
    output jsu_pkg::t_group o_group
);
    import jsu_pkg::*;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_hcnt, n_hcnt;
    logic [11:0] r_cp, n_cp;
    logic [4:0]  hv;
    logic [15:0] cp16;
    t_group      grp;

    assign hv   = hex_val(i_byte);
    assign cp16 = {r_cp, hv[3:0]};

    always_comb begin
        n_phase   = r_phase;
        n_hcnt    = r_hcnt;
        n_cp      = r_cp;
        grp.cnt   = 2'd0;
        grp.kind  = K_DATA;
        grp.bytes = '0;
        if (i_end) begin
            grp.cnt = 2'd1;
            n_phase = PH_WAIT;
            case (r_phase)
                PH_WAIT: grp.kind = K_NOQUOTE;
                PH_STR:  grp.kind = K_UNTERM;
                PH_ESC:  grp.kind = K_TRAILBS;
                default: grp.kind = K_SHORTU;
            endcase
        end else begin
            case (r_phase)
                PH_WAIT: begin
                    if (i_byte == CH_QUOTE) begin
                        n_phase = PH_STR;
                    end else begin
                        grp.cnt  = 2'd1;
                        grp.kind = K_NOQUOTE;
                    end
                end
                PH_STR: begin
                    if (i_byte == CH_QUOTE) begin
                        grp.cnt  = 2'd1;
                        grp.kind = K_DONE;
                        n_phase  = PH_WAIT;
                    end else if (i_byte == CH_BSLASH) begin
                        n_phase = PH_ESC;
                    end else begin
                        grp.cnt      = 2'd1;
                        grp.bytes[0] = i_byte;
                    end
                end
                PH_ESC: begin
                    grp.cnt = 2'd1;
                    n_phase = PH_STR;
                    case (i_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: grp.bytes[0] = i_byte;
                        CH_B: grp.bytes[0] = 8'h08;
                        CH_F: grp.bytes[0] = 8'h0C;
                        CH_N: grp.bytes[0] = 8'h0A;
                        CH_R: grp.bytes[0] = 8'h0D;
                        CH_T: grp.bytes[0] = 8'h09;
                        CH_U: begin
                            grp.cnt = 2'd0;
                            n_hcnt  = 2'd0;
                            n_cp    = 12'd0;
                            n_phase = PH_HEX;
                        end
                        default: begin
                            grp.kind = K_UNKESC;
                            n_phase  = PH_WAIT;
                        end
                    endcase
                end
                default: begin
                    if (!hv[4]) begin
                        grp.cnt  = 2'd1;
                        grp.kind = K_BADHEX;
                        n_phase  = PH_WAIT;
                    end else begin
                        n_cp = cp16[11:0];
                        if (r_hcnt == 2'd3) begin
                            grp     = utf8_enc(cp16);
                            n_hcnt  = 2'd0;
                            n_phase = PH_STR;
                        end else begin
                            n_hcnt = r_hcnt + 2'd1;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_WAIT;
            r_hcnt  <= 2'd0;
            r_cp    <= 12'd0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_hcnt  <= n_hcnt;
            r_cp    <= n_cp;
        end
    end

    assign o_group = grp;

endmodule

`default_nettype wire

// ----- design/jsu_emit.sv -----
// jsu_emit: result register; holds one decoded group and hands its words out
// one per cycle while the sink is ready. Depends on jsu_pkg.
`default_nettype none

module jsu_emit (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_load,
    input  jsu_pkg::t_group i_group,
    output logic            o_can_load,
    output logic            o_valid,
    input  wire             i_ready,
    output logic [7:0]      o_byte,
    output jsu_pkg::t_kind  o_kind,
    output logic            o_last
);
    import jsu_pkg::*;

    logic [1:0]      r_cnt;
    t_kind           r_kind;
    logic [2:0][7:0] r_bytes;
    logic            pop;

    assign o_valid    = (r_cnt != 2'd0);
    assign pop        = o_valid && i_ready;
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (i_load) begin
            r_cnt <= i_group.cnt;
        end else if (pop) begin
            r_cnt <= r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_kind  <= i_group.kind;
            r_bytes <= i_group.bytes;
        end else if (pop) begin
            r_bytes[0] <= r_bytes[1];
            r_bytes[1] <= r_bytes[2];
        end
    end

    assign o_byte = r_bytes[0];
    assign o_kind = r_kind;
    assign o_last = (r_cnt == 2'd1);

endmodule

`default_nettype wire

// ----- design/json_string_unescape.sv -----
// json_string_unescape: top level of the streaming JSON string unescaper.
// Instantiates jsu_decode and jsu_emit; depends on jsu_pkg.
//
// Takes one source byte (or an end-of-buffer mark) per word and returns the
// decoded UTF-8 bytes, a done word at the closing quote, or an error word.
// The decoder is combinational logic in front of a result register that
// holds the up to three words one input produces. A new input is taken every
// cycle while that register holds at most one word the sink is taking, so
// plain bytes flow at one per cycle; an input that yields two or three words
// (the final hex digit of a \u escape) holds the input side while the result
// register drains.
`default_nettype none

module json_string_unescape (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [7:0]          i_in_byte,
    input  wire                 i_end_of_buffer,
    output logic                o_valid,
    input  wire                 i_ready,
    output logic [7:0]          o_out_byte,
    output logic [2:0]          o_kind,
    output logic                o_last
);
    import jsu_pkg::*;

    t_group grp;
    t_kind  kind;
    logic   fire;

    assign fire = i_valid && o_ready;

    jsu_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (i_in_byte),
        .i_end   (i_end_of_buffer),
        .o_group (grp)
    );

    jsu_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_group    (grp),
        .o_can_load (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_byte     (o_out_byte),
        .o_kind     (kind),
        .o_last     (o_last)
    );

    assign o_kind = kind;

endmodule

`default_nettype wire

// ----- design/jsu_checker.sv -----
// jsu_checker: port-level assertions for json_string_unescape, bound to the
// top level. Depends on jsu_pkg.
`default_nettype none

module jsu_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_valid,
    input wire       o_ready,
    input wire [7:0] i_in_byte,
    input wire       i_end_of_buffer,
    input wire       o_valid,
    input wire       i_ready,
    input wire [7:0] o_out_byte,
    input wire [2:0] o_kind,
    input wire       o_last
);
    import jsu_pkg::*;

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != K_DATA |-> o_last)
        else $error("status word not marked last");

    a_status_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_kind != K_DATA |-> o_out_byte == 8'd0)
        else $error("status word carries nonzero byte");

    a_group_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_last |=> o_valid && o_kind == K_DATA)
        else $error("multi-byte group broken");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte) && $stable(o_kind)
            && $stable(o_last))
        else $error("stalled output changed");

endmodule

bind json_string_unescape jsu_checker u_chk (.*);

`default_nettype wire

// ----- tb/sv/json_string_unescape_checker.sv -----
// json_string_unescape_checker: watches both channels of json_string_unescape,
// predicts the result words of each accepted input word and compares them in order.
// Depends on jsu_pkg for the kind and phase enums and the character codes.
module json_string_unescape_checker
    import jsu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_eob,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic [2:0] i_out_kind,
    input  logic       i_out_last,
    output int         o_errors,
    output int         o_pending,
    output int         o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } decoded_word_t;

    decoded_word_t decoded_q[$];
    t_phase        str_phase;
    logic [2:0]    digit_count;
    logic [15:0]   code_acc;
    int            errors;
    int            checked;

    function automatic logic [4:0] nibble_of(input logic [7:0] c);
        if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
        if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h61 + 8'd10)};
        if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h41 + 8'd10)};
        return 5'd0;
    endfunction

    task automatic unescape_word(input logic [7:0] c, input logic eob);
        logic [7:0]    res_byte [3];
        t_kind         res_kind;
        int            n;
        logic [4:0]    nib;
        logic [7:0]    esc;
        bit            esc_ok;
        decoded_word_t w;
        n = 0;
        res_kind = K_DATA;
        res_byte = '{default: 8'h00};
        esc = 8'h00;
        if (eob) begin
            n = 1;
            case (str_phase)
                PH_WAIT: res_kind = K_NOQUOTE;
                PH_STR:  res_kind = K_UNTERM;
                PH_ESC:  res_kind = K_TRAILBS;
                default: res_kind = K_SHORTU;
            endcase
            str_phase = PH_WAIT;
        end else begin
            case (str_phase)
                PH_WAIT: begin
                    if (c == CH_QUOTE) begin
                        str_phase = PH_STR;
                    end else begin
                        n = 1;
                        res_kind = K_NOQUOTE;
                    end
                end
                PH_STR: begin
                    if (c == CH_QUOTE) begin
                        n = 1;
                        res_kind = K_DONE;
                        str_phase = PH_WAIT;
                    end else if (c == CH_BSLASH) begin
                        str_phase = PH_ESC;
                    end else begin
                        n = 1;
                        res_byte[0] = c;
                    end
                end
                PH_ESC: begin
                    esc_ok = 1'b1;
                    case (c)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: esc = c;
                        CH_B: esc = 8'h08;
                        CH_F: esc = 8'h0C;
                        CH_N: esc = 8'h0A;
                        CH_R: esc = 8'h0D;
                        CH_T: esc = 8'h09;
                        default: esc_ok = 1'b0;
                    endcase
                    if (esc_ok) begin
                        n = 1;
                        res_byte[0] = esc;
                        str_phase = PH_STR;
                    end else if (c == CH_U) begin
                        digit_count = 3'd0;
                        code_acc = 16'h0000;
                        str_phase = PH_HEX;
                    end else begin
                        n = 1;
                        res_kind = K_UNKESC;
                        str_phase = PH_WAIT;
                    end
                end
                default: begin
                    nib = nibble_of(c);
                    if (!nib[4]) begin
                        n = 1;
                        res_kind = K_BADHEX;
                        str_phase = PH_WAIT;
                    end else begin
                        code_acc = {code_acc[11:0], nib[3:0]};
                        digit_count = digit_count + 3'd1;
                        if (digit_count >= 3'd4) begin
                            if (code_acc < 16'h0080) begin
                                n = 1;
                                res_byte[0] = code_acc[7:0];
                            end else if (code_acc < 16'h0800) begin
                                n = 2;
                                res_byte[0] = 8'hC0 | 8'(code_acc >> 6);
                                res_byte[1] = 8'h80 | (code_acc[7:0] & 8'h3F);
                            end else begin
                                n = 3;
                                res_byte[0] = 8'hE0 | 8'(code_acc >> 12);
                                res_byte[1] = 8'h80 | (8'(code_acc >> 6) & 8'h3F);
                                res_byte[2] = 8'h80 | (code_acc[7:0] & 8'h3F);
                            end
                            digit_count = 3'd0;
                            str_phase = PH_STR;
                        end
                    end
                end
            endcase
        end
        for (int i = 0; i < n; i++) begin
            w.data = res_byte[i];
            w.kind = res_kind;
            w.last = (i == n - 1);
            decoded_q.push_back(w);
        end
    endtask

    always @(posedge i_clk) begin
        decoded_word_t w;
        if (!i_rst_n) begin
            str_phase = PH_WAIT;
            digit_count = 3'd0;
            code_acc = 16'h0000;
            decoded_q.delete();
            errors = 0;
            checked = 0;
        end else begin
            if (i_in_valid && i_in_ready) begin
                unescape_word(i_in_byte, i_in_eob);
            end
            if (i_out_valid && i_out_ready) begin
                if (decoded_q.size() == 0) begin
                    $display("%0t: unexpected result word: byte %02h kind %0d last %0b",
                             $realtime, i_out_byte, i_out_kind, i_out_last);
                    errors++;
                end else begin
                    w = decoded_q.pop_front();
                    checked++;
                    if (i_out_byte !== w.data || i_out_kind !== w.kind
                            || i_out_last !== w.last) begin
                        $display("%0t: mismatch: expected byte %02h kind %0d last %0b, got byte %02h kind %0d last %0b",
                                 $realtime, w.data, w.kind, w.last,
                                 i_out_byte, i_out_kind, i_out_last);
                        errors++;
                    end
                end
            end
        end
        o_errors  <= errors;
        o_pending <= decoded_q.size();
        o_checked <= checked;
    end

endmodule

// ----- tb/sv/json_string_unescape_tb.sv -----
// json_string_unescape_tb: drives quoted strings, escapes, \u sequences and broken
// input into json_string_unescape with random gaps on both sides.
// Depends on jsu_pkg, json_string_unescape and json_string_unescape_checker.
module json_string_unescape_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import jsu_pkg::*;

    typedef enum int {
        FLAW_NONE,
        FLAW_EOB_STR,
        FLAW_EOB_ESC,
        FLAW_EOB_HEX,
        FLAW_BAD_HEX,
        FLAW_UNK_ESC,
        FLAW_NOISE
    } flaw_t;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [7:0] i_in_byte = 8'h00;
    logic       i_end_of_buffer = 1'b0;
    logic       i_ready = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [7:0] o_out_byte;
    logic [2:0] o_kind;
    logic       o_last;

    int errors;
    int pending;
    int checked;
    int words_sent = 0;
    int strings_sent = 0;
    bit steady = 1'b0;

    json_string_unescape dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_in_byte       (i_in_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_kind          (o_kind),
        .o_last          (o_last)
    );

    json_string_unescape_checker checker_i (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_in_byte   (i_in_byte),
        .i_in_eob    (i_end_of_buffer),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_out_byte  (o_out_byte),
        .i_out_kind  (o_kind),
        .i_out_last  (o_last),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_checked   (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5ms;
        $display("json_string_unescape_tb: done, errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) return 8'h30 + {4'h0, v};
        if ($urandom_range(0, 1)) return 8'h41 + {4'h0, v} - 8'd10;
        return 8'h61 + {4'h0, v} - 8'd10;
    endfunction

    task automatic send_word(input logic [7:0] b, input logic eob);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_byte <= b;
        i_end_of_buffer <= eob;
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    task automatic send_unicode(input logic [15:0] cp);
        send_word(CH_BSLASH, 1'b0);
        send_word(CH_U, 1'b0);
        send_word(hex_char(cp[15:12]), 1'b0);
        send_word(hex_char(cp[11:8]), 1'b0);
        send_word(hex_char(cp[7:4]), 1'b0);
        send_word(hex_char(cp[3:0]), 1'b0);
    endtask

    initial begin : sink_drive
        int gap;
        forever begin
            gap = pick_gap();
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin : stimulus
        flaw_t      flaw;
        int         n_elem;
        int         at;
        bit         cut;
        logic [7:0] b;
        logic [15:0] cp;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // outside a string: end mark and a stray byte
        send_word(8'hFF, 1'b1);
        send_word(8'hFF, 1'b0);
        // \u0000 and \uFFFF, then close
        send_word(CH_QUOTE, 1'b0);
        send_unicode(16'h0000);
        send_unicode(16'hFFFF);
        send_word(CH_QUOTE, 1'b0);
        // unterminated string
        send_word(CH_QUOTE, 1'b0);
        send_word(8'h00, 1'b1);
        // trailing backslash
        send_word(CH_QUOTE, 1'b0);
        send_word(CH_BSLASH, 1'b0);
        send_word(8'h00, 1'b1);
        // short \u
        send_word(CH_QUOTE, 1'b0);
        send_word(CH_BSLASH, 1'b0);
        send_word(CH_U, 1'b0);
        send_word(8'h31, 1'b0);
        send_word(8'h00, 1'b1);
        // quote among hex digits
        send_word(CH_QUOTE, 1'b0);
        send_word(CH_BSLASH, 1'b0);
        send_word(CH_U, 1'b0);
        send_word(8'h31, 1'b0);
        send_word(CH_QUOTE, 1'b0);
        // unknown escape
        send_word(CH_QUOTE, 1'b0);
        send_word(CH_BSLASH, 1'b0);
        send_word(8'h71, 1'b0);
        strings_sent = 7;

        while (words_sent < 270) begin
            steady = (strings_sent >= 20 && strings_sent < 28);
            flaw = ($urandom_range(0, 99) < 70) ? FLAW_NONE : flaw_t'($urandom_range(1, 6));
            n_elem = $urandom_range(0, 6);
            at = $urandom_range(0, n_elem);
            if (flaw == FLAW_NOISE) begin
                repeat ($urandom_range(1, 3)) begin
                    do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
                    send_word(b, $urandom_range(0, 3) == 0);
                end
            end
            send_word(CH_QUOTE, 1'b0);
            cut = 1'b0;
            for (int i = 0; i <= n_elem && !cut; i++) begin
                if (i == at && flaw != FLAW_NONE && flaw != FLAW_NOISE) begin
                    cut = 1'b1;
                    case (flaw)
                        FLAW_EOB_STR: send_word(8'($urandom_range(0, 255)), 1'b1);
                        FLAW_EOB_ESC: begin
                            send_word(CH_BSLASH, 1'b0);
                            send_word(8'($urandom_range(0, 255)), 1'b1);
                        end
                        FLAW_EOB_HEX, FLAW_BAD_HEX: begin
                            send_word(CH_BSLASH, 1'b0);
                            send_word(CH_U, 1'b0);
                            repeat ($urandom_range(0, 3))
                                send_word(hex_char(4'($urandom_range(0, 15))), 1'b0);
                            if (flaw == FLAW_EOB_HEX) begin
                                send_word(8'($urandom_range(0, 255)), 1'b1);
                            end else begin
                                do b = 8'($urandom_range(0, 255));
                                while ((b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46)
                                       || (b >= 8'h61 && b <= 8'h66));
                                send_word(b, 1'b0);
                            end
                        end
                        default: begin
                            send_word(CH_BSLASH, 1'b0);
                            do b = 8'($urandom_range(0, 255));
                            while (b == CH_QUOTE || b == CH_BSLASH || b == CH_SLASH
                                   || b == CH_B || b == CH_F || b == CH_N || b == CH_R
                                   || b == CH_T || b == CH_U);
                            send_word(b, 1'b0);
                        end
                    endcase
                end else if (i < n_elem) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4: begin
                            do b = 8'($urandom_range(0, 255));
                            while (b == CH_QUOTE || b == CH_BSLASH);
                            send_word(b, 1'b0);
                        end
                        5, 6: begin
                            case ($urandom_range(0, 7))
                                0: b = CH_QUOTE;
                                1: b = CH_BSLASH;
                                2: b = CH_SLASH;
                                3: b = CH_B;
                                4: b = CH_F;
                                5: b = CH_N;
                                6: b = CH_R;
                                default: b = CH_T;
                            endcase
                            send_word(CH_BSLASH, 1'b0);
                            send_word(b, 1'b0);
                        end
                        default: begin
                            case ($urandom_range(0, 2))
                                0: cp = 16'($urandom_range(0, 16'h007F));
                                1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
                                default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
                            endcase
                            send_unicode(cp);
                        end
                    endcase
                end
            end
            if (!cut) send_word(CH_QUOTE, 1'b0);
            strings_sent++;
        end
        steady = 1'b0;
        i_valid <= 1'b0;

        // let the checker count the last accepted word before waiting on it
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        $display("json_string_unescape_tb: %0d input words in %0d strings sent",
                 words_sent, strings_sent);
        $display("json_string_unescape_tb: %0d result words compared, %0d failures",
                 checked, errors);
        if (errors == 0 && pending == 0) begin
            $display("json_string_unescape_tb: done, clean");
        end else begin
            $display("json_string_unescape_tb: done, errors");
        end
        $finish;
    end

endmodule
